// File: hw/rtl/sbpr_pkg.sv
package sbpr_pkg;

   // Frame layout
   localparam int HEADER_BYTES = 6;
   localparam int CNT_W        = 9;

   // Header byte positions (sync sits at position 0, dest id at the last one)
   localparam logic [CNT_W-1:0] HDR_LENGTH = CNT_W'(1);
   localparam logic [CNT_W-1:0] HDR_CMD_HI = CNT_W'(2);
   localparam logic [CNT_W-1:0] HDR_CMD_LO = CNT_W'(3);
   localparam logic [CNT_W-1:0] HDR_SOURCE = CNT_W'(4);
   localparam logic [CNT_W-1:0] HDR_LAST   = CNT_W'(HEADER_BYTES - 1);
   localparam logic [CNT_W-1:0] HDR_END    = CNT_W'(HEADER_BYTES);

   // Frame status codes
   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_NAK     = 2'd1;
   localparam logic [1:0] STATUS_GIVE_UP = 2'd2;

   // CSR indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_VALUE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT = 2'd2;

   // Reset values of the CSRs
   localparam logic [7:0] SYNC_VALUE_RST  = 8'd5;
   localparam logic [7:0] MAX_PAYLOAD_RST = 8'd248;
   localparam logic [7:0] RETRY_LIMIT_RST = 8'd3;

   typedef enum logic [1:0] {
      PH_HUNT     = 2'd0,
      PH_HEADER   = 2'd1,
      PH_PAYLOAD  = 2'd2,
      PH_CHECKSUM = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] sync_value;
      logic [7:0] max_payload;
      logic [7:0] retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic        frame_end;
      logic [1:0]  frame_status;
      logic        nak_request;
      logic [15:0] command_word;
      logic [7:0]  source_id;
      logic [7:0]  dest_id;
   } rsp_type;

endpackage

// File: hw/rtl/sbpr_in_reg.sv
module sbpr_in_reg import sbpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

// File: hw/rtl/sbpr_parser.sv
module sbpr_parser import sbpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       emit,
   output rsp_type    result
);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       length_ff, length_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       chk_hi_ff, chk_hi_in;
   logic [15:0]      cmd_ff, cmd_in;
   logic [7:0]       src_ff, src_in;
   logic [7:0]       dst_ff, dst_in;
   logic [7:0]       fail_ff, fail_in;

   logic             sync_hit;
   logic             too_long;
   logic             cks_high;
   logic             cks_match;
   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] cks_pos;
   logic [CNT_W-1:0] pay_done;
   logic [CNT_W-1:0] pay_pos;
   logic [15:0]      sum_add;

   assign sync_hit  = (rx_byte == cfg.sync_value);
   assign too_long  = (count_ff == HDR_LENGTH) && (rx_byte > cfg.max_payload);
   assign count_inc = count_ff + CNT_W'(1);
   assign cks_pos   = HDR_END + {1'b0, length_ff};
   assign cks_high  = (count_ff == cks_pos);
   assign cks_match = ({chk_hi_ff, rx_byte} == sum_ff);
   assign pay_done  = count_inc - HDR_END;
   assign pay_pos   = count_ff - HDR_END;
   assign sum_add   = sum_ff + {8'b0, rx_byte};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HUNT: begin
            phase_in = sync_hit ? PH_HEADER : PH_HUNT;
         end
         PH_HEADER: begin
            if (too_long) begin
               phase_in = sync_hit ? PH_HEADER : PH_HUNT;
            end else if (count_ff == HDR_LAST) begin
               phase_in = (length_ff == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (pay_done >= {1'b0, length_ff}) begin
               phase_in = PH_CHECKSUM;
            end
         end
         PH_CHECKSUM: begin
            if (!cks_high) begin
               phase_in = PH_HUNT;
            end
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   // datapath and result
   always_comb begin
      count_in  = count_ff;
      length_in = length_ff;
      sum_in    = sum_ff;
      chk_hi_in = chk_hi_ff;
      cmd_in    = cmd_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      fail_in   = fail_ff;
      emit      = 1'b0;

      result.payload_byte  = 8'd0;
      result.payload_index = length_ff;
      result.frame_end     = 1'b0;
      result.frame_status  = STATUS_GOOD;
      result.nak_request   = 1'b0;
      result.command_word  = cmd_ff;
      result.source_id     = src_ff;
      result.dest_id       = dst_ff;

      case (phase_ff)
         PH_HUNT: begin
            if (sync_hit) begin
               count_in  = CNT_W'(1);
               sum_in    = {8'b0, rx_byte};
               length_in = 8'd0;
            end else begin
               count_in = '0;
            end
         end
         PH_HEADER: begin
            if (too_long) begin
               // length byte is rescanned as a possible sync
               if (sync_hit) begin
                  count_in  = CNT_W'(1);
                  sum_in    = {8'b0, rx_byte};
                  length_in = 8'd0;
               end else begin
                  count_in = '0;
               end
            end else begin
               case (count_ff)
                  HDR_LENGTH: length_in    = rx_byte;
                  HDR_CMD_HI: cmd_in[15:8] = rx_byte;
                  HDR_CMD_LO: cmd_in[7:0]  = rx_byte;
                  HDR_SOURCE: src_in       = rx_byte;
                  default:    dst_in       = rx_byte;
               endcase
               sum_in   = sum_add;
               count_in = count_inc;
            end
         end
         PH_PAYLOAD: begin
            sum_in               = sum_add;
            count_in             = count_inc;
            emit                 = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = pay_pos[7:0];
         end
         PH_CHECKSUM: begin
            if (cks_high) begin
               chk_hi_in = rx_byte;
               count_in  = count_inc;
            end else begin
               emit             = 1'b1;
               result.frame_end = 1'b1;
               count_in         = '0;
               if (cks_match) begin
                  fail_in = 8'd0;
               end else if (fail_ff == cfg.retry_limit) begin
                  result.frame_status = STATUS_GIVE_UP;
                  result.nak_request  = 1'b1;
                  fail_in             = 8'd0;
               end else begin
                  result.frame_status = STATUS_NAK;
                  result.nak_request  = 1'b1;
                  fail_in             = fail_ff + 8'd1;
               end
            end
         end
         default: count_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         count_ff  <= '0;
         length_ff <= '0;
         sum_ff    <= '0;
         chk_hi_ff <= '0;
         cmd_ff    <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
         fail_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         sum_ff    <= sum_in;
         chk_hi_ff <= chk_hi_in;
         cmd_ff    <= cmd_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         fail_ff   <= fail_in;
      end
   end

`ifndef SYNTHESIS
   a_hunt_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HUNT |-> count_ff == '0)
      else $error("byte count not clear while hunting");

   a_header_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> (count_ff >= HDR_LENGTH) && (count_ff <= HDR_LAST))
      else $error("byte count outside header");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> (count_ff >= HDR_END) && (count_ff < cks_pos))
      else $error("byte count outside payload");

   a_checksum_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CHECKSUM |-> (count_ff == cks_pos) || (count_ff == cks_pos + CNT_W'(1)))
      else $error("byte count outside checksum");

   a_end_hunts: assert property (@(posedge clock) disable iff (reset)
      step && emit && result.frame_end |=> phase_ff == PH_HUNT)
      else $error("frame end did not return to hunting");
`endif

endmodule

// File: hw/rtl/sbpr_out_reg.sv
module sbpr_out_reg import sbpr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type data,
   output logic    out_free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: hw/rtl/sync_byte_packet_receiver.sv
// Sync-byte framed receiver with a 16-bit additive checksum.
// req_ channel: one link byte per transfer (req_rx_byte). The receiver hunts
//   for the sync byte, then takes length, command (high byte first), source
//   and destination ids, then the payload and a big-endian checksum word.
// rsp_ channel: one transfer per payload byte, plus one closing transfer on
//   the checksum low byte carrying frame_end, frame_status and nak_request.
//   Header, sync and checksum-high bytes produce no transfer.
// csr_ channel: index 0 sync value, 1 max payload, 2 retry limit; always
//   ready, writes to other indexes are dropped. Write only while idle.
// Path: a byte accepted on req_ goes through the input register, the
//   parser step and the output register to rsp_. Throughput: one byte per
//   cycle unless rsp_ stalls, set by the parser between the two registers.
// Reset (synchronous, active high): CSRs return to 5 / 248 / 3, parser goes
//   back to hunting with all counters and the failure count cleared.
// Stall: when rsp_ready is low and a result is waiting, a byte that would
//   produce a result waits in the input register; bytes that produce none
//   still drain. req_ready drops once the input register cannot move.
module sync_byte_packet_receiver import sbpr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // byte input
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   // result output
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_payload_byte,
   output logic [7:0]           rsp_payload_index,
   output logic                 rsp_frame_end,
   output logic [1:0]           rsp_frame_status,
   output logic                 rsp_nak_request,
   output logic [15:0]          rsp_command_word,
   output logic [7:0]           rsp_source_id,
   output logic [7:0]           rsp_dest_id,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid;
   logic [7:0] in_byte;
   logic       advance;
   logic       emit;
   logic       out_free;
   rsp_type    result;
   rsp_type    rsp_data;

   // CSR file: a write lands at once, the parser sees it on the next byte
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNC_VALUE:  cfg_in.sync_value  = csr_wdata;
            CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata;
            CSR_RETRY_LIMIT: cfg_in.retry_limit = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value  <= SYNC_VALUE_RST;
         cfg_ff.max_payload <= MAX_PAYLOAD_RST;
         cfg_ff.retry_limit <= RETRY_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A held byte steps the parser when its result (if any) has a free slot
   assign advance = in_valid && (out_free || !emit);

   sbpr_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   sbpr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step    (advance),
      .rx_byte (in_byte),
      .emit    (emit),
      .result  (result)
   );

   sbpr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .data      (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_payload_byte  = rsp_data.payload_byte;
   assign rsp_payload_index = rsp_data.payload_index;
   assign rsp_frame_end     = rsp_data.frame_end;
   assign rsp_frame_status  = rsp_data.frame_status;
   assign rsp_nak_request   = rsp_data.nak_request;
   assign rsp_command_word  = rsp_data.command_word;
   assign rsp_source_id     = rsp_data.source_id;
   assign rsp_dest_id       = rsp_data.dest_id;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(advance && emit))
      else $error("result register overwritten while stalled");

   a_nak_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_nak_request == (rsp_frame_status != STATUS_GOOD))
      else $error("nak request disagrees with frame status");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> rsp_frame_status == STATUS_GOOD
         && rsp_nak_request == 1'b0)
      else $error("status on a payload result");
`endif

endmodule
